### hw/rtl/irle_pkg.sv
// Package for the interlaced run-length image decoder.
// Holds beat structs, command codes, decode phases and default geometry.
// No dependencies.
package irle_pkg;

	localparam int LINE_LIMIT_DEFAULT = 639;
	localparam int IMAGE_ROWS_DEFAULT = 480;

	localparam logic [7:0] CODE_FRAME = 8'd33;
	localparam logic [7:0] CODE_FIELD = 8'd34;
	localparam logic [7:0] CODE_TRUNC = 8'd35;
	localparam logic [7:0] CODE_EXT   = 8'd36;

	localparam logic [9:0] ROW_MAX   = 10'd1023;
	localparam logic [9:0] TOTAL_MAX = 10'd1023;
	localparam logic [7:0] LEN_MAX   = 8'd255;

	typedef enum logic [3:0] {
		PH_CMD  = 4'b0001,
		PH_LEN  = 4'b0010,
		PH_SKIP = 4'b0100,
		PH_END  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
	} in_beat_t;

	typedef struct packed {
		logic [9:0] row;
		logic [9:0] column;
		logic [7:0] run_length;
		logic [5:0] pixel_color;
		logic       line_done;
		logic       frame_end;
		logic       beyond_image;
	} out_beat_t;

endpackage

### hw/rtl/interlaced_rle_image_decoder.sv
// Interlaced run-length image decoder: one stream byte per beat in, at most one run per beat out.
// Depends on irle_pkg.
// An input beat passes through the input register and then the result register.
// Throughput: 1 byte per cycle unless stalled; position update is one add and compare per byte.
// Reset: arst_n clears position, line count, previous color and phase; no clearing pass.
// start_req on a beat clears position, line count and phase before that byte.
module interlaced_rle_image_decoder #(
	parameter int LINE_LIMIT = irle_pkg::LINE_LIMIT_DEFAULT,
	parameter int IMAGE_ROWS = irle_pkg::IMAGE_ROWS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  irle_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output irle_pkg::out_beat_t out_data
);

	localparam logic [9:0]  LL10 = 10'(LINE_LIMIT);
	localparam logic [10:0] LL11 = 11'(LINE_LIMIT);
	localparam logic [10:0] IR11 = 11'(IMAGE_ROWS);

	logic               valid_s1;
	irle_pkg::in_beat_t data_s1;

	logic [9:0]       col_q;
	logic [9:0]       row_q;
	logic [9:0]       total_q;
	logic [5:0]       color_q;
	irle_pkg::phase_t phase_q;

	logic                out_valid_q;
	irle_pkg::out_beat_t out_q;

	logic [9:0]       eff_col;
	logic [9:0]       eff_row;
	logic [9:0]       eff_total;
	irle_pkg::phase_t eff_phase;

	logic [7:0]  b;
	logic [1:0]  hi;
	logic [9:0]  fill_len;
	logic [10:0] cnt_sum;
	logic        cnt_full;
	logic [10:0] short_sum;

	logic             res_valid;
	logic [9:0]       res_len;
	logic [5:0]       res_color;
	logic             res_forced;
	logic             res_frame;
	logic             row_to_one;
	logic [9:0]       total_new;
	irle_pkg::phase_t phase_new;

	logic [10:0] next_col;
	logic        done;
	logic [10:0] row_inc;
	logic [9:0]  row_adv;

	logic advance;

	assign advance  = valid_s1 && (!res_valid || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_comb begin
		eff_col   = data_s1.start_req ? 10'd0 : col_q;
		eff_row   = data_s1.start_req ? 10'd0 : row_q;
		eff_total = data_s1.start_req ? 10'd0 : total_q;
		eff_phase = data_s1.start_req ? irle_pkg::PH_CMD : phase_q;
	end

	always_comb begin
		b         = data_s1.data_byte;
		hi        = b[7:6];
		fill_len  = LL10 - eff_col;
		cnt_sum   = {1'b0, eff_total} + {3'b000, b};
		cnt_full  = cnt_sum >= LL11;
		short_sum = {1'b0, eff_total} + {9'd0, hi};

		res_valid  = 1'b0;
		res_len    = {2'b00, b};
		res_color  = color_q;
		res_forced = 1'b0;
		res_frame  = 1'b0;
		row_to_one = 1'b0;
		total_new  = eff_total;
		phase_new  = eff_phase;

		unique case (eff_phase)
			irle_pkg::PH_LEN: begin
				res_valid  = 1'b1;
				res_forced = cnt_full;
				total_new  = (cnt_sum > {1'b0, irle_pkg::TOTAL_MAX}) ? irle_pkg::TOTAL_MAX
					: cnt_sum[9:0];
				phase_new  = cnt_full ? irle_pkg::PH_SKIP : irle_pkg::PH_CMD;
			end
			irle_pkg::PH_SKIP: begin
				phase_new = irle_pkg::PH_CMD;
			end
			irle_pkg::PH_END: begin
				phase_new = irle_pkg::PH_END;
			end
			default: begin
				if (hi != 2'b00) begin
					res_valid = 1'b1;
					res_len   = {8'd0, hi};
					res_color = b[5:0];
					total_new = (short_sum > {1'b0, irle_pkg::TOTAL_MAX}) ? irle_pkg::TOTAL_MAX
						: short_sum[9:0];
				end else begin
					unique case (b)
						irle_pkg::CODE_EXT: begin
							phase_new = irle_pkg::PH_LEN;
						end
						irle_pkg::CODE_TRUNC: begin
							res_valid  = eff_col != 10'd0;
							res_len    = fill_len;
							res_forced = 1'b1;
						end
						irle_pkg::CODE_FIELD: begin
							res_valid  = 1'b1;
							res_len    = fill_len;
							res_forced = 1'b1;
							row_to_one = 1'b1;
						end
						irle_pkg::CODE_FRAME: begin
							res_valid  = 1'b1;
							res_len    = fill_len;
							res_forced = 1'b1;
							res_frame  = 1'b1;
							phase_new  = irle_pkg::PH_END;
						end
						default: begin
							res_valid  = 1'b1;
							res_forced = cnt_full;
							total_new  = (cnt_sum > {1'b0, irle_pkg::TOTAL_MAX})
								? irle_pkg::TOTAL_MAX : cnt_sum[9:0];
							phase_new  = cnt_full ? irle_pkg::PH_SKIP : irle_pkg::PH_CMD;
						end
					endcase
				end
			end
		endcase

		next_col = {1'b0, eff_col} + {1'b0, res_len};
		done     = res_forced || (next_col >= LL11);
		row_inc  = {1'b0, eff_row} + 11'd2;
		row_adv  = (row_inc > {1'b0, irle_pkg::ROW_MAX}) ? irle_pkg::ROW_MAX : row_inc[9:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= 10'd0;
			row_q   <= 10'd0;
			total_q <= 10'd0;
			color_q <= 6'd0;
			phase_q <= irle_pkg::PH_CMD;
		end else if (advance) begin
			phase_q <= phase_new;
			if (res_valid) begin
				color_q <= res_color;
				if (done) begin
					col_q   <= 10'd0;
					total_q <= 10'd0;
					row_q   <= row_to_one ? 10'd1 : row_adv;
				end else begin
					col_q   <= next_col[9:0];
					total_q <= total_new;
					row_q   <= eff_row;
				end
			end else begin
				col_q   <= eff_col;
				row_q   <= eff_row;
				total_q <= total_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q.row          <= eff_row;
			out_q.column       <= eff_col;
			out_q.run_length   <= (res_len > {2'b00, irle_pkg::LEN_MAX}) ? irle_pkg::LEN_MAX
				: res_len[7:0];
			out_q.pixel_color  <= res_color;
			out_q.line_done    <= done;
			out_q.frame_end    <= res_frame;
			out_q.beyond_image <= {1'b0, eff_row} >= IR11;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("decode phase lost its one-hot code");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_frame_is_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.frame_end) |-> out_q.line_done)
		else $error("frame end run does not close its line");

	a_frame_enters_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && res_frame) |=> (phase_q == irle_pkg::PH_END))
		else $error("frame end did not enter ended phase");

	a_open_run_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.line_done) |->
		(({1'b0, out_q.column} + {3'b000, out_q.run_length}) < LL11))
		else $error("run that leaves the line open reaches the line limit");

endmodule
